[rtl/wmhp_pkg.sv]
`default_nettype none

package wmhp_pkg;

   localparam int unsigned CountWidth   = 6;
   localparam int unsigned AddrWidth    = 48;
   localparam int unsigned AddrSlots    = 4;
   localparam int unsigned AddrBytes    = 6;

   localparam logic [1:0] FRAME_TYPE_CONTROL = 2'd1;
   localparam logic [1:0] FRAME_TYPE_DATA    = 2'd2;

   localparam logic [CountWidth-1:0] COUNT_MAX      = 6'd63;
   localparam logic [CountWidth-1:0] POS_FC_LOW     = 6'd0;
   localparam logic [CountWidth-1:0] POS_FC_HIGH    = 6'd1;
   localparam logic [CountWidth-1:0] POS_SEQ_LOW    = 6'd22;
   localparam logic [CountWidth-1:0] POS_SEQ_HIGH   = 6'd23;

   // first byte position of A1..A4
   localparam logic [CountWidth-1:0] ADDR_BASE [AddrSlots] = '{6'd4, 6'd10, 6'd16, 6'd24};

   localparam logic [5:0] LEN_CONTROL = 6'd10;
   localparam logic [5:0] LEN_BASE    = 6'd24;
   localparam logic [5:0] LEN_WDS     = 6'd6;
   localparam logic [5:0] LEN_QOS     = 6'd2;
   localparam logic [5:0] LEN_HTC     = 6'd4;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic                 valid_res;
      logic [1:0]           frame_type;
      logic [3:0]           frame_subtype;
      logic                 to_ds;
      logic                 from_ds;
      logic                 protected_flag;
      logic                 qos_data;
      logic [11:0]          sequence_number;
      logic [5:0]           header_length;
      logic [AddrWidth-1:0] dest_address;
      logic [AddrWidth-1:0] source_address;
      logic [AddrWidth-1:0] bssid_address;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/wifi_mac_header_parser.sv]
// The last byte of a frame passes the input register; its result is then registered in the output register.
// Throughput: one byte per cycle; the input register stalls only when a
// last byte waits behind an unaccepted result in the output register.
// Reset (synchronous, active high) clears the byte counter and valid flags;
// header capture registers are not reset, each is written before it is read.
`default_nettype none

module wifi_mac_header_parser
   import wmhp_pkg::*;
(
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  wire     rsp_stall,
   output rsp_type rsp_data
);

   logic                  in_valid_ff;
   req_type               in_data_ff;
   logic                  in_move;
   logic                  req_accept;

   logic [CountWidth-1:0] cnt_ff, cnt_in;
   logic [7:0]            fc_low_ff, fc_low_in;
   logic [7:0]            fc_high_ff, fc_high_in;
   logic [15:0]           seq_ff, seq_in;
   logic [AddrWidth-1:0]  addr_ff [AddrSlots];
   logic [AddrWidth-1:0]  addr_in [AddrSlots];

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic [CountWidth:0]   frame_len;
   logic [1:0]            f_type;
   logic [3:0]            f_sub;
   logic                  f_tds, f_fds, f_prot, f_qos;
   logic [5:0]            f_hlen;

   assign in_move    = in_valid_ff && (!in_data_ff.last_byte || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !in_move;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // capture by byte position
   always_comb begin
      fc_low_in  = fc_low_ff;
      fc_high_in = fc_high_ff;
      seq_in     = seq_ff;
      if (cnt_ff == POS_FC_LOW)   fc_low_in    = in_data_ff.frame_byte;
      if (cnt_ff == POS_FC_HIGH)  fc_high_in   = in_data_ff.frame_byte;
      if (cnt_ff == POS_SEQ_LOW)  seq_in[7:0]  = in_data_ff.frame_byte;
      if (cnt_ff == POS_SEQ_HIGH) seq_in[15:8] = in_data_ff.frame_byte;
      for (int s = 0; s < AddrSlots; s++) begin
         addr_in[s] = addr_ff[s];
         for (int k = 0; k < AddrBytes; k++) begin
            if (cnt_ff == CountWidth'(ADDR_BASE[s] + CountWidth'(k))) begin
               addr_in[s][8*k +: 8] = in_data_ff.frame_byte;
            end
         end
      end
   end

   always_comb begin
      if (in_data_ff.last_byte) begin
         cnt_in = '0;
      end else if (cnt_ff != COUNT_MAX) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // header decode on the view that includes the current byte
   assign frame_len = {1'b0, cnt_ff} + 1'b1;
   assign f_type    = fc_low_in[3:2];
   assign f_sub     = fc_low_in[7:4];
   assign f_tds     = fc_high_in[0];
   assign f_fds     = fc_high_in[1];
   assign f_prot    = fc_high_in[6];
   assign f_qos     = (f_type == FRAME_TYPE_DATA) && f_sub[3];
   assign f_hlen    = LEN_BASE + ((f_tds && f_fds) ? LEN_WDS : 6'd0)
                    + (f_qos ? LEN_QOS : 6'd0)
                    + ((f_qos && fc_high_in[7]) ? LEN_HTC : 6'd0);

   always_comb begin
      rsp_data_in = '0;
      if (frame_len >= {1'b0, LEN_CONTROL}) begin
         if (f_type == FRAME_TYPE_CONTROL) begin
            rsp_data_in.valid_res      = 1'b1;
            rsp_data_in.frame_type     = f_type;
            rsp_data_in.frame_subtype  = f_sub;
            rsp_data_in.to_ds          = f_tds;
            rsp_data_in.from_ds        = f_fds;
            rsp_data_in.protected_flag = f_prot;
            rsp_data_in.header_length  = LEN_CONTROL;
            rsp_data_in.dest_address   = addr_in[0];
         end else if (frame_len >= {1'b0, LEN_BASE} && frame_len >= {1'b0, f_hlen}) begin
            rsp_data_in.valid_res       = 1'b1;
            rsp_data_in.frame_type      = f_type;
            rsp_data_in.frame_subtype   = f_sub;
            rsp_data_in.to_ds           = f_tds;
            rsp_data_in.from_ds         = f_fds;
            rsp_data_in.protected_flag  = f_prot;
            rsp_data_in.qos_data        = f_qos;
            rsp_data_in.sequence_number = seq_in[15:4];
            rsp_data_in.header_length   = f_hlen;
            unique case ({f_tds, f_fds})
               2'b00: begin
                  rsp_data_in.dest_address   = addr_in[0];
                  rsp_data_in.source_address = addr_in[1];
                  rsp_data_in.bssid_address  = addr_in[2];
               end
               2'b01: begin
                  rsp_data_in.dest_address   = addr_in[0];
                  rsp_data_in.bssid_address  = addr_in[1];
                  rsp_data_in.source_address = addr_in[2];
               end
               2'b10: begin
                  rsp_data_in.bssid_address  = addr_in[0];
                  rsp_data_in.source_address = addr_in[1];
                  rsp_data_in.dest_address   = addr_in[2];
               end
               default: begin
                  rsp_data_in.dest_address   = addr_in[2];
                  rsp_data_in.source_address = addr_in[3];
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            in_valid_ff <= 1'b1;
         end else if (in_move) begin
            in_valid_ff <= 1'b0;
         end
         if (in_move) begin
            cnt_ff <= cnt_in;
         end
         if (in_move && in_data_ff.last_byte) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (in_move) begin
         fc_low_ff  <= fc_low_in;
         fc_high_ff <= fc_high_in;
         seq_ff     <= seq_in;
         for (int s = 0; s < AddrSlots; s++) begin
            addr_ff[s] <= addr_in[s];
         end
      end
      if (in_move && in_data_ff.last_byte) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // a short frame reports nothing but the zero valid flag
   a_short_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.valid_res |->
         rsp_data_ff.header_length == 6'd0 && rsp_data_ff.dest_address == '0
         && rsp_data_ff.sequence_number == 12'd0)
      else $error("short frame result carries nonzero fields");

   a_control_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.valid_res && rsp_data_ff.frame_type == FRAME_TYPE_CONTROL
      |-> rsp_data_ff.header_length == LEN_CONTROL && rsp_data_ff.source_address == '0)
      else $error("control frame result malformed");

   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      in_move && in_data_ff.last_byte |=> cnt_ff == '0)
      else $error("byte counter not restarted after last byte");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_data_ff.last_byte && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

[verif/tb_wifi_mac_header_parser.sv]
`default_nettype none

module tb_wifi_mac_header_parser;
   import wmhp_pkg::*;

   localparam logic [1:0] FRAME_TYPE_MGMT = 2'd0;
   localparam logic [1:0] FRAME_TYPE_EXT  = 2'd3;

   localparam int unsigned RANDOM_BYTES = 560;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned DRAIN_CYCLES = 8;

   typedef enum logic [1:0] {
      DS_NONE = 2'b00,
      DS_FROM = 2'b01,
      DS_TO   = 2'b10,
      DS_WDS  = 2'b11
   } ds_role_type;

   typedef enum logic [1:0] {FILL_CONST, FILL_COUNT, FILL_RAND} fill_type;

   typedef struct {
      int unsigned len;
      logic [7:0]  fc0;
      logic [7:0]  fc1;
      fill_type    fill;
      logic [7:0]  fill_byte;
      bit          pinned;
      rsp_type     pin;
   } frame_spec_type;

   typedef struct {
      bit      pinned;
      rsp_type value;
   } pin_type;

   bit      clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   wifi_mac_header_parser u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Directed frames; a typed header is used in place of the parser model
   // where the answer is plain (too short, all zeros, all ones).
   frame_spec_type directed_frames [21] = '{
      '{1,  8'h00, 8'h00, FILL_CONST, 8'h00, 1'b1, '0},
      '{9,  8'hC4, 8'h43, FILL_CONST, 8'hFF, 1'b1, '0},
      '{10, 8'hC4, 8'h43, FILL_CONST, 8'hFF, 1'b1,
        {1'b1, FRAME_TYPE_CONTROL, 4'hC, 1'b1, 1'b1, 1'b1, 1'b0, 12'h000, LEN_CONTROL,
         48'hFFFF_FFFF_FFFF, 48'h0, 48'h0}},
      '{23, 8'h80, 8'h00, FILL_CONST, 8'h00, 1'b1, '0},
      '{24, 8'h00, 8'h00, FILL_CONST, 8'h00, 1'b1,
        {1'b1, FRAME_TYPE_MGMT, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 12'h000, LEN_BASE,
         48'h0, 48'h0, 48'h0}},
      '{29, 8'h08, 8'h03, FILL_COUNT, 8'h00, 1'b1, '0},
      '{25, 8'h88, 8'h00, FILL_COUNT, 8'h00, 1'b1, '0},
      '{35, 8'h88, 8'h83, FILL_COUNT, 8'h00, 1'b1, '0},
      '{70, 8'hFF, 8'hFF, FILL_CONST, 8'hFF, 1'b1,
        {1'b1, FRAME_TYPE_EXT, 4'hF, 1'b1, 1'b1, 1'b1, 1'b0, 12'hFFF, 6'd30,
         48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h0}},
      '{24, 8'h80, 8'h00, FILL_COUNT, 8'h00, 1'b0, '0},
      '{24, 8'h08, 8'h02, FILL_COUNT, 8'h00, 1'b0, '0},
      '{24, 8'h08, 8'h01, FILL_COUNT, 8'h00, 1'b0, '0},
      '{30, 8'h08, 8'h03, FILL_COUNT, 8'h00, 1'b0, '0},
      '{26, 8'h88, 8'h41, FILL_COUNT, 8'h00, 1'b0, '0},
      '{30, 8'h88, 8'h80, FILL_RAND,  8'h00, 1'b0, '0},
      '{36, 8'h88, 8'hC3, FILL_RAND,  8'h00, 1'b0, '0},
      '{20, 8'hB4, 8'h10, FILL_RAND,  8'h00, 1'b0, '0},
      '{24, 8'h8C, 8'h02, FILL_RAND,  8'h00, 1'b0, '0},
      '{28, 8'hD0, 8'h80, FILL_RAND,  8'h00, 1'b0, '0},
      '{64, 8'h08, 8'h00, FILL_RAND,  8'h00, 1'b0, '0},
      '{2,  8'hFF, 8'hFF, FILL_RAND,  8'h00, 1'b0, '0}
   };

   // parser model state
   logic [CountWidth-1:0] byte_cnt;
   logic [7:0]            fc_low;
   logic [7:0]            fc_high;
   logic [AddrWidth-1:0]  addr_slot [AddrSlots];
   logic [15:0]           seq_ctl;

   rsp_type     header_q [$];
   pin_type     pin_q [$];
   int unsigned idle_cycles;
   int unsigned mismatches;
   int unsigned frames_sent;
   int unsigned bytes_sent;
   int unsigned headers_checked;
   int unsigned short_frames;

   function automatic void clear_tracker();
      byte_cnt = '0;
      fc_low   = '0;
      fc_high  = '0;
      seq_ctl  = '0;
      for (int s = 0; s < AddrSlots; s++) addr_slot[s] = '0;
   endfunction

   function automatic void capture_byte(logic [CountWidth-1:0] pos, logic [7:0] b);
      int unsigned off;
      case (pos)
         POS_FC_LOW:   fc_low = b;
         POS_FC_HIGH:  fc_high = b;
         POS_SEQ_LOW:  seq_ctl[7:0] = b;
         POS_SEQ_HIGH: seq_ctl[15:8] = b;
         default: begin
            for (int s = 0; s < AddrSlots; s++) begin
               if (32'(pos) >= 32'(ADDR_BASE[s])
                   && 32'(pos) < 32'(ADDR_BASE[s]) + AddrBytes) begin
                  off = 32'(pos - ADDR_BASE[s]);
                  addr_slot[s][8*off +: 8] = b;
               end
            end
         end
      endcase
   endfunction

   function automatic logic qos_of(logic [7:0] fcl);
      return (fcl[3:2] == FRAME_TYPE_DATA) && fcl[7];
   endfunction

   function automatic logic [5:0] header_len_of(logic [7:0] fcl, logic [7:0] fch);
      logic [5:0] n;
      if (fcl[3:2] == FRAME_TYPE_CONTROL) return LEN_CONTROL;
      n = LEN_BASE;
      if (fch[0] && fch[1]) n += LEN_WDS;
      if (qos_of(fcl)) n += LEN_QOS;
      if (qos_of(fcl) && fch[7]) n += LEN_HTC;
      return n;
   endfunction

   function automatic rsp_type decode_header(int unsigned len);
      rsp_type r;
      r = '0;
      // control needs 10 bytes, anything else at least 24 plus its extensions
      if (len < 32'(header_len_of(fc_low, fc_high))) return r;
      r.valid_res      = 1'b1;
      r.frame_type     = fc_low[3:2];
      r.frame_subtype  = fc_low[7:4];
      r.to_ds          = fc_high[0];
      r.from_ds        = fc_high[1];
      r.protected_flag = fc_high[6];
      r.header_length  = header_len_of(fc_low, fc_high);
      if (r.frame_type == FRAME_TYPE_CONTROL) begin
         r.dest_address = addr_slot[0];
         return r;
      end
      r.qos_data        = qos_of(fc_low);
      r.sequence_number = seq_ctl[15:4];
      case (ds_role_type'({fc_high[0], fc_high[1]}))
         DS_NONE: begin
            r.dest_address   = addr_slot[0];
            r.source_address = addr_slot[1];
            r.bssid_address  = addr_slot[2];
         end
         DS_FROM: begin
            r.dest_address   = addr_slot[0];
            r.bssid_address  = addr_slot[1];
            r.source_address = addr_slot[2];
         end
         DS_TO: begin
            r.bssid_address  = addr_slot[0];
            r.source_address = addr_slot[1];
            r.dest_address   = addr_slot[2];
         end
         default: begin
            r.dest_address   = addr_slot[2];
            r.source_address = addr_slot[3];
         end
      endcase
      return r;
   endfunction

   function automatic void check_field(string name, logic [47:0] want, logic [47:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_header(rsp_type want, rsp_type got);
      check_field("valid_res", 48'(want.valid_res), 48'(got.valid_res));
      check_field("frame_type", 48'(want.frame_type), 48'(got.frame_type));
      check_field("frame_subtype", 48'(want.frame_subtype), 48'(got.frame_subtype));
      check_field("to_ds", 48'(want.to_ds), 48'(got.to_ds));
      check_field("from_ds", 48'(want.from_ds), 48'(got.from_ds));
      check_field("protected_flag", 48'(want.protected_flag), 48'(got.protected_flag));
      check_field("qos_data", 48'(want.qos_data), 48'(got.qos_data));
      check_field("sequence_number", 48'(want.sequence_number),
                  48'(got.sequence_number));
      check_field("header_length", 48'(want.header_length), 48'(got.header_length));
      check_field("dest_address", want.dest_address, got.dest_address);
      check_field("source_address", want.source_address, got.source_address);
      check_field("bssid_address", want.bssid_address, got.bssid_address);
   endfunction

   // mostly no pause or a short one, now and then a long one; none when steady
   function automatic int unsigned pause_len(bit steady);
      int unsigned r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   always @(posedge clock) begin
      logic [CountWidth-1:0] pos;
      rsp_type               hdr;
      pin_type               pin;
      if (reset) begin
         clear_tracker();
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_valid && !req_stall) begin
            pos = byte_cnt;
            capture_byte(pos, req_data.frame_byte);
            if (req_data.last_byte) begin
               hdr = decode_header(32'(pos) + 1);
               pin = pin_q.pop_front();
               header_q.push_back(pin.pinned ? pin.value : hdr);
               clear_tracker();
            end else if (byte_cnt != COUNT_MAX) begin
               byte_cnt++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (header_q.size() == 0) begin
               $error("header result with none pending");
               mismatches++;
            end else begin
               hdr = header_q.pop_front();
               if (!hdr.valid_res) short_frames++;
               headers_checked++;
               check_header(hdr, rsp_data);
            end
         end
      end
   end

   initial begin
      bit          quiet;
      int unsigned n;
      quiet = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 63) == 0) quiet = !quiet;
         n = pause_len(quiet);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_byte(logic [7:0] b, logic last, bit steady);
      int unsigned gap;
      gap = pause_len(steady);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{frame_byte: b, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(frame_spec_type f, bit steady);
      logic [7:0] b;
      pin_type    pin;
      pin.pinned = f.pinned;
      pin.value  = f.pin;
      pin_q.push_back(pin);
      for (int unsigned p = 0; p < f.len; p++) begin
         if (p == 0) b = f.fc0;
         else if (p == 1) b = f.fc1;
         else if (f.fill == FILL_CONST) b = f.fill_byte;
         else if (f.fill == FILL_COUNT) b = p[7:0];
         else b = 8'($urandom_range(0, 255));
         send_byte(b, p == f.len - 1, steady);
      end
      frames_sent++;
   endtask

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      frame_spec_type f;
      int unsigned    need;
      int unsigned    r;
      int unsigned    random_start;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      mismatches      = 0;
      frames_sent     = 0;
      bytes_sent      = 0;
      headers_checked = 0;
      short_frames    = 0;
      idle_cycles     = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_frames[i]) send_frame(directed_frames[i], $urandom_range(0, 1) == 0);

      // random frames: mostly well formed, some cut short, some padded long
      random_start = bytes_sent;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         f.fc0       = 8'($urandom_range(0, 255));
         f.fc1       = 8'($urandom_range(0, 255));
         f.fill      = FILL_RAND;
         f.fill_byte = '0;
         f.pinned    = 1'b0;
         f.pin       = '0;
         need = 32'(header_len_of(f.fc0, f.fc1));
         r = $urandom_range(0, 99);
         if (r < 70) f.len = need + $urandom_range(0, 4);
         else if (r < 88) f.len = $urandom_range(1, need - 1);
         else f.len = $urandom_range(need, 80);
         send_frame(f, $urandom_range(0, 3) == 0);
      end
      req_valid <= 1'b0;

      while (header_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d frames in %0d byte transfers; checked %0d headers, %0d flagged short.",
               frames_sent, bytes_sent, headers_checked, short_frames);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
rtl/wmhp_pkg.sv
rtl/wifi_mac_header_parser.sv
verif/tb_wifi_mac_header_parser.sv
